@@ rtl/assert_macros.svh @@
// Assertion macros shared by the filter RTL.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/iirdf1_pkg.sv @@
// Types and constants of the direct-form-one IIR filter.
// No dependencies; used by iirdf1_mac and iir_direct_form_one_filter_core.
package iirdf1_pkg;

   // Q2.14 coefficients
   localparam int COEF_BITS      = 16;
   localparam int FRAC_BITS      = 14;
   // headroom for the sum of up to seven products
   localparam int ACC_GUARD_BITS = 3;

   // register map
   localparam int NUM_REGS       = 7;
   localparam int REG_IDX_BITS   = 3;
   localparam int REG_FWD_0      = 0;
   localparam int REG_FB_0       = 4;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   localparam coef_type COEF_UNITY = 16'sd16384;

   // sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic sub;
   } mac_ctl_type;

endpackage

@@ rtl/iirdf1_mac.sv @@
// Shared multiply-accumulate unit: one registered product per cycle while mul_en is high, then accumulate.
// Depends on iirdf1_pkg.
module iirdf1_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  iirdf1_pkg::mac_ctl_type      ctl,
   input  iirdf1_pkg::coef_type         coef,
   input  logic signed [SAMPLE_BITS-1:0] data,
   output logic signed [SAMPLE_BITS+iirdf1_pkg::COEF_BITS+iirdf1_pkg::ACC_GUARD_BITS-1:0] acc
);
   import iirdf1_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + ACC_GUARD_BITS;

   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                        prod_vld_ff;
   logic                        prod_sub_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [ACC_BITS-1:0]  acc_ff;

   // multiplier stage
   assign prod_in = coef * data;

   // accumulate the registered product
   always_comb begin
      priority if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff && prod_sub_ff) begin
         acc_in = acc_ff - ACC_BITS'(prod_ff);
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul_en && !ctl.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff     <= prod_in;
         prod_sub_ff <= ctl.sub;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ rtl/iir_direct_form_one_filter_core.sv @@
// Direct-form-one IIR filter core: 2*ORDER+1 taps through one shared multiplier.
// One word at a time: a new input is stalled until the single multiply-accumulate unit's word leaves ST_FINISH.
// The next input is taken while a finished result still waits on rsp_stall.
// Reset (synchronous): histories zero, forward_coef_0 = 1.0, other coefficients zero.
// Depends on iirdf1_pkg, iirdf1_mac and assert_macros.svh.
`include "assert_macros.svh"

module iir_direct_form_one_filter_core #(
   parameter int ORDER       = 2,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample_out,
   output logic                                    rsp_clipped,
   input  logic                                    csr_we,
   input  logic [iirdf1_pkg::REG_IDX_BITS-1:0]     csr_index,
   input  logic [iirdf1_pkg::COEF_BITS-1:0]        csr_wdata
);
   import iirdf1_pkg::*;

   localparam int NTAPS         = 2 * ORDER + 1;
   localparam int TAP_BITS      = $clog2(NTAPS + 1);
   localparam int HIST_IDX_BITS = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int ACC_BITS      = SAMPLE_BITS + COEF_BITS + ACC_GUARD_BITS;
   localparam int ROUND_BITS    = ACC_BITS + 1;
   localparam int SHIFT_BITS    = ROUND_BITS - FRAC_BITS;

   localparam logic signed [ROUND_BITS-1:0] ROUND_HALF = ROUND_BITS'(2 ** (FRAC_BITS - 1));
   localparam logic signed [SHIFT_BITS-1:0] SAT_HI =
      {{(SHIFT_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [SHIFT_BITS-1:0] SAT_LO =
      {{(SHIFT_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MAC    = 2'd1;
   localparam logic [1:0] ST_ROUND  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [TAP_BITS-1:0]          tap_ff, tap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                         rsp_clip_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [SAMPLE_BITS-1:0] xh_ff [ORDER];
   logic signed [SAMPLE_BITS-1:0] yh_ff [ORDER];
   logic signed [SAMPLE_BITS-1:0] res_y_ff, res_y_in;
   logic                         res_clip_ff, res_clip_in;
   coef_type                     coef_ff [NUM_REGS];

   logic                         req_take;
   logic                         finish_go;
   logic                         taps_done;
   mac_ctl_type                  mac_ctl;
   coef_type                     coef_sel;
   logic signed [SAMPLE_BITS-1:0] data_sel;
   logic                         sub_sel;
   logic signed [ACC_BITS-1:0]   mac_acc;
   logic signed [ROUND_BITS-1:0] round_sum;
   logic signed [SHIFT_BITS-1:0] rounded;
   logic [TAP_BITS-1:0]          fwd_off;
   logic [TAP_BITS-1:0]          fb_off;

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign taps_done = (tap_ff == TAP_BITS'(NTAPS));

   // tap select: b0*x, then b[i]*x[n-i], then a[j]*y[n-1-j] subtracted
   assign fwd_off = tap_ff - TAP_BITS'(1);
   assign fb_off  = tap_ff - TAP_BITS'(ORDER + 1);

   always_comb begin
      priority if (tap_ff == '0) begin
         coef_sel = coef_ff[REG_IDX_BITS'(REG_FWD_0)];
         data_sel = x_ff;
         sub_sel  = 1'b0;
      end else if (tap_ff <= TAP_BITS'(ORDER)) begin
         coef_sel = coef_ff[REG_IDX_BITS'(REG_FWD_0) + REG_IDX_BITS'(tap_ff)];
         data_sel = xh_ff[HIST_IDX_BITS'(fwd_off)];
         sub_sel  = 1'b0;
      end else begin
         coef_sel = coef_ff[REG_IDX_BITS'(REG_FB_0) + REG_IDX_BITS'(fb_off)];
         data_sel = yh_ff[HIST_IDX_BITS'(fb_off)];
         sub_sel  = 1'b1;
      end
   end

   assign mac_ctl.clear  = req_take;
   assign mac_ctl.mul_en = (state_ff == ST_MAC) && !taps_done;
   assign mac_ctl.sub    = sub_sel;

   iirdf1_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (coef_sel),
      .data  (data_sel),
      .acc   (mac_acc)
   );

   // round half up, floor shift, saturate
   assign round_sum = ROUND_BITS'(mac_acc) + ROUND_HALF;
   assign rounded   = round_sum[ROUND_BITS-1:FRAC_BITS];

   always_comb begin
      priority if (rounded > SAT_HI) begin
         res_y_in    = OUT_MAX;
         res_clip_in = 1'b1;
      end else if (rounded < SAT_LO) begin
         res_y_in    = OUT_MIN;
         res_clip_in = 1'b1;
      end else begin
         res_y_in    = rounded[SAMPLE_BITS-1:0];
         res_clip_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_MAC;
               tap_in   = '0;
            end
         end
         ST_MAC: begin
            if (taps_done) begin
               state_in = ST_ROUND;
            end else begin
               tap_in = tap_ff + TAP_BITS'(1);
            end
         end
         ST_ROUND: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word register
   always_comb begin
      priority if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_sample_in;
      end
      if (state_ff == ST_ROUND) begin
         res_y_ff    <= res_y_in;
         res_clip_ff <= res_clip_in;
      end
      if (finish_go) begin
         rsp_sample_ff <= res_y_ff;
         rsp_clip_ff   <= res_clip_ff;
      end
   end

   // sample histories, newest first
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ORDER; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (finish_go) begin
         for (int i = ORDER - 1; i > 0; i--) begin
            xh_ff[i] <= xh_ff[i-1];
            yh_ff[i] <= yh_ff[i-1];
         end
         xh_ff[0] <= x_ff;
         yh_ff[0] <= res_y_ff;
      end
   end

   // coefficient registers; index past the map is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[REG_FWD_0] <= COEF_UNITY;
      end else if (csr_we && (csr_index < REG_IDX_BITS'(NUM_REGS))) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   // checks
   `ASSERT_IMPLY(a_tap_bound, clock, reset, state_ff == ST_MAC, tap_ff <= TAP_BITS'(NTAPS))
   `ASSERT_NEXT(a_round_to_finish, clock, reset, state_ff == ST_ROUND, state_ff == ST_FINISH)
   `ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `ASSERT_IMPLY(a_clip_at_rail, clock, reset, rsp_valid_ff && rsp_clip_ff, (rsp_sample_ff == OUT_MAX) || (rsp_sample_ff == OUT_MIN))

endmodule
